/* rtl/u8srd_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-8 script range detector package
// Shared constants, the script range table and the types that pass between
// the modules of the detector.
// ----------------------------------------------------------------------------
package u8srd_pkg;

    localparam int unsigned RangeCount = 18;

    typedef logic [20:0] t_code_point;
    typedef logic [15:0] t_position;
    typedef logic [1:0]  t_cont_count;

    localparam t_position PosMax          = 16'hFFFF;
    localparam t_position CheckLimitReset = 16'd2048;

    // Lead byte patterns: the byte masked with LeadMaskN equals LeadTagN.
    localparam logic [7:0] LeadMask2 = 8'hE0;
    localparam logic [7:0] LeadTag2  = 8'hC0;
    localparam logic [7:0] LeadMask3 = 8'hF0;
    localparam logic [7:0] LeadTag3  = 8'hE0;
    localparam logic [7:0] LeadMask4 = 8'hF8;
    localparam logic [7:0] LeadTag4  = 8'hF0;

    localparam t_cont_count ContNone  = 2'd0;
    localparam t_cont_count ContOne   = 2'd1;
    localparam t_cont_count ContTwo   = 2'd2;
    localparam t_cont_count ContThree = 2'd3;

    // Inclusive bounds of the listed scripts: CJK, hiragana, katakana, Arabic,
    // Cyrillic, Hebrew, Thai, the Indic blocks, Hangul jamo and syllables.
    localparam t_code_point RangeLo [RangeCount] = '{
        21'h04e00, 21'h03040, 21'h030a0, 21'h00600, 21'h00400, 21'h00590,
        21'h00e00, 21'h00900, 21'h00980, 21'h00a00, 21'h00a80, 21'h00b00,
        21'h00b80, 21'h00c00, 21'h00c80, 21'h00d00, 21'h01100, 21'h0ac00
    };
    localparam t_code_point RangeHi [RangeCount] = '{
        21'h09fff, 21'h0309f, 21'h030ff, 21'h006ff, 21'h004ff, 21'h005ff,
        21'h00e7f, 21'h0097f, 21'h009ff, 21'h00a7f, 21'h00aff, 21'h00b7f,
        21'h00bff, 21'h00c7f, 21'h00cff, 21'h00d7f, 21'h011ff, 21'h0d7a3
    };

    // One byte moving from the input register into the decoder.
    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       end_of_doc;
    } t_step;

    // End-of-document result leaving the decoder.
    typedef struct packed {
        logic valid;
        logic non_english_found;
    } t_result;

endpackage

/* rtl/u8srd_if.sv */
// ----------------------------------------------------------------------------
// UTF-8 script range detector channels
// Valid/ready channels for document bytes, results and the limit register.
// ----------------------------------------------------------------------------
interface u8srd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_doc;

    modport source (output valid, output data_byte, output end_of_doc, input ready);
    modport sink   (input valid, input data_byte, input end_of_doc, output ready);
endinterface

interface u8srd_flag_if;
    logic valid;
    logic ready;
    logic non_english_found;

    modport source (output valid, output non_english_found, input ready);
    modport sink   (input valid, input non_english_found, output ready);
endinterface

interface u8srd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] check_limit;

    modport source (output valid, output check_limit, input ready);
    modport sink   (input valid, input check_limit, output ready);
endinterface

/* rtl/u8srd_range_match.sv */
// ----------------------------------------------------------------------------
// UTF-8 script range matcher
// Compares one code point against every listed script range in parallel.
// ----------------------------------------------------------------------------
module u8srd_range_match (
    input  u8srd_pkg::t_code_point i_code_point,
    output logic                   o_hit
);

    logic [u8srd_pkg::RangeCount-1:0] range_hit;

    always_comb begin
        for (int k = 0; k < u8srd_pkg::RangeCount; k++) begin
            range_hit[k] = (i_code_point >= u8srd_pkg::RangeLo[k]) &&
                           (i_code_point <= u8srd_pkg::RangeHi[k]);
        end
    end

    assign o_hit = |range_hit;

endmodule

/* rtl/u8srd_decode.sv */
// ----------------------------------------------------------------------------
// UTF-8 script range decoder
// Holds the per-document decode state and folds in one byte per cycle.
// ----------------------------------------------------------------------------
module u8srd_decode (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  u8srd_pkg::t_position   i_check_limit,
    input  u8srd_pkg::t_step       i_step,
    output u8srd_pkg::t_result     o_result
);

    u8srd_pkg::t_position   r_pos,     n_pos;
    u8srd_pkg::t_cont_count r_cont,    n_cont;
    u8srd_pkg::t_code_point r_partial, n_partial;
    logic                   r_match,   n_match;

    logic                   in_window;
    logic                   completes;
    logic                   hit;
    u8srd_pkg::t_code_point cp_next;

    assign in_window = r_pos < i_check_limit;
    assign cp_next   = {r_partial[14:0], i_step.data_byte[5:0]};
    assign completes = in_window && (r_cont == u8srd_pkg::ContOne);

    u8srd_range_match u_match (
        .i_code_point (cp_next),
        .o_hit        (hit)
    );

    always_comb begin
        n_pos     = r_pos;
        n_cont    = r_cont;
        n_partial = r_partial;
        n_match   = r_match;
        if (i_step.valid) begin
            if (in_window) begin
                if (r_cont != u8srd_pkg::ContNone) begin
                    n_partial = cp_next;
                    n_cont    = r_cont - 2'd1;
                    if (completes && hit) begin
                        n_match = 1'b1;
                    end
                end else if ((i_step.data_byte & u8srd_pkg::LeadMask2) ==
                             u8srd_pkg::LeadTag2) begin
                    n_partial = {16'd0, i_step.data_byte[4:0]};
                    n_cont    = u8srd_pkg::ContOne;
                end else if ((i_step.data_byte & u8srd_pkg::LeadMask3) ==
                             u8srd_pkg::LeadTag3) begin
                    n_partial = {17'd0, i_step.data_byte[3:0]};
                    n_cont    = u8srd_pkg::ContTwo;
                end else if ((i_step.data_byte & u8srd_pkg::LeadMask4) ==
                             u8srd_pkg::LeadTag4) begin
                    n_partial = {18'd0, i_step.data_byte[2:0]};
                    n_cont    = u8srd_pkg::ContThree;
                end
            end
            if (r_pos != u8srd_pkg::PosMax) begin
                n_pos = r_pos + 16'd1;
            end
            if (i_step.end_of_doc) begin
                n_pos     = '0;
                n_cont    = u8srd_pkg::ContNone;
                n_partial = '0;
                n_match   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_cont    <= u8srd_pkg::ContNone;
            r_partial <= '0;
            r_match   <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_cont    <= n_cont;
            r_partial <= n_partial;
            r_match   <= n_match;
        end
    end

    assign o_result.valid             = i_step.valid && i_step.end_of_doc;
    assign o_result.non_english_found = r_match || (completes && hit);

    a_clear_after_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step.valid && i_step.end_of_doc |=>
            r_pos == '0 && r_cont == u8srd_pkg::ContNone && !r_match)
        else $error("decode state not cleared after the last byte");

    a_pos_advance : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step.valid && !i_step.end_of_doc && r_pos != u8srd_pkg::PosMax |=>
            r_pos == $past(r_pos) + 16'd1)
        else $error("byte position did not advance by one");

    a_match_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_match && !(i_step.valid && i_step.end_of_doc) |=> r_match)
        else $error("match flag dropped inside a document");

endmodule

/* rtl/utf8_script_range_detector_core.sv */
// ----------------------------------------------------------------------------
// UTF-8 script range detector core
// Scans the leading bytes of a document for code points in listed scripts.
// ----------------------------------------------------------------------------
// The block takes one document byte per clock cycle without pause, as long as
// results are taken when offered. Each accepted byte is held in an input
// register. When it is folded in, a single stage of decode logic (lead byte
// recognition, the six-bit shift of a continuation byte and eighteen parallel
// range compares) updates the document state. On the byte marked as last, the
// flag is written into the result register at the end of that cycle. The flag
// is therefore offered only from the result register, once its last byte has
// passed through the input register and has been folded in. The
// input register and the result register are parted: a pending result holds
// back only a following last byte, and the bytes queued behind it, never the
// ordinary bytes before it. The scan window comes from the check_limit
// register, which resets to 2048 and is written through its own channel,
// always ready. A write applies from the next byte that is folded in, so it
// should only be made between documents.
// ----------------------------------------------------------------------------
module utf8_script_range_detector_core (
    input  logic    i_clk,
    input  logic    i_rst_n,
    u8srd_cfg_if.sink    i_cfg,
    u8srd_byte_if.sink   i_byte,
    u8srd_flag_if.source o_flag
);

    // Window length, taken from the configuration channel.
    u8srd_pkg::t_position r_check_limit;

    // Input register holding one accepted byte request.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Result register towards the output channel.
    logic r_out_valid;
    logic r_out_flag;

    logic                 fire;
    u8srd_pkg::t_step     step;
    u8srd_pkg::t_result   result;

    // A held byte is folded in when it produces no result, or when the
    // result register is empty or being emptied in this cycle.
    assign fire = r_in_valid && (!r_in_last || !r_out_valid || o_flag.ready);

    assign i_byte.ready = !r_in_valid || fire;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_limit <= u8srd_pkg::CheckLimitReset;
        end else if (i_cfg.valid) begin
            r_check_limit <= i_cfg.check_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
            r_in_last <= i_byte.end_of_doc;
        end
    end

    assign step.valid      = fire;
    assign step.data_byte  = r_in_byte;
    assign step.end_of_doc = r_in_last;

    u8srd_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_check_limit (r_check_limit),
        .i_step        (step),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_flag.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.valid) begin
            r_out_flag <= result.non_english_found;
        end
    end

    assign o_flag.valid             = r_out_valid;
    assign o_flag.non_english_found = r_out_flag;

    // A last byte that is folded in must leave a result behind.
    a_last_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in_last |=> r_out_valid)
        else $error("last byte processed without a result");

    // A result that waits must never be overwritten by the next document.
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_flag.ready |-> !(fire && r_in_last))
        else $error("pending result overwritten");

    // A held byte that is neither folded in nor replaced stays in place.
    a_held_byte_kept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !fire |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_last))
        else $error("held byte lost while stalled");

endmodule

/* bench/tb_utf8_script_range_detector_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the UTF-8 script range detector core
// Drives documents byte by byte into the core, predicts the end-of-document
// flag with an independent decoder model, and compares every flag the core
// returns. Directed documents cover range edges, cut and broken sequences,
// scan windows and documents that run past the window. Random traffic then
// runs under several sender and receiver pacing profiles.
// ----------------------------------------------------------------------------
module tb_utf8_script_range_detector_core;

    // Clock period is 4 ns; the run is abandoned if it goes past this count.
    localparam int unsigned CycleLimit  = 1_000_000;
    // Idle cycles allowed after the last flag has arrived, covering the
    // path from the input register to the result register.
    localparam int unsigned DrainCycles = 6;
    // Longest gap the sender inserts before one request.
    localparam int unsigned MaxGap      = 30;

    // Lead byte recognition: byte & mask == tag.
    localparam logic [7:0] Lead2Mask = 8'hE0;
    localparam logic [7:0] Lead2Tag  = 8'hC0;
    localparam logic [7:0] Lead3Mask = 8'hF0;
    localparam logic [7:0] Lead3Tag  = 8'hE0;
    localparam logic [7:0] Lead4Mask = 8'hF8;
    localparam logic [7:0] Lead4Tag  = 8'hF0;
    localparam logic [1:0] ContTag   = 2'b10;

    localparam logic [15:0] PosSat       = 16'hFFFF;
    localparam logic [15:0] LimitAtReset = 16'd2048;

    // Inclusive bounds of the listed scripts, in the order CJK, hiragana,
    // katakana, Arabic, Cyrillic, Hebrew, Thai, the Indic blocks, Hangul
    // jamo and Hangul syllables.
    localparam int unsigned ScriptCount = 18;
    localparam logic [20:0] ScriptLo [ScriptCount] = '{
        21'h04e00, 21'h03040, 21'h030a0, 21'h00600, 21'h00400, 21'h00590,
        21'h00e00, 21'h00900, 21'h00980, 21'h00a00, 21'h00a80, 21'h00b00,
        21'h00b80, 21'h00c00, 21'h00c80, 21'h00d00, 21'h01100, 21'h0ac00
    };
    localparam logic [20:0] ScriptHi [ScriptCount] = '{
        21'h09fff, 21'h0309f, 21'h030ff, 21'h006ff, 21'h004ff, 21'h005ff,
        21'h00e7f, 21'h0097f, 21'h009ff, 21'h00a7f, 21'h00aff, 21'h00b7f,
        21'h00bff, 21'h00c7f, 21'h00cff, 21'h00d7f, 21'h011ff, 21'h0d7a3
    };

    logic clk;
    logic rst_n;

    u8srd_cfg_if  cfg_bus ();
    u8srd_byte_if byte_bus ();
    u8srd_flag_if flag_bus ();

    utf8_script_range_detector_core u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_bus),
        .i_byte  (byte_bus),
        .o_flag  (flag_bus)
    );

    // Pacing of both channels, set per test. A percentage is the chance that
    // a given cycle is spent idle (sender) or stalled (receiver).
    int unsigned src_idle_pct     = 0;
    int unsigned sink_stall_pct   = 0;
    int unsigned flag_hold_cycles = 0;

    // Decoder model state, a private copy of what the core should hold.
    logic [15:0] win_limit;
    logic [15:0] doc_pos;
    logic [1:0]  cont_left;
    logic [20:0] partial_cp;
    logic        script_seen;

    // Flags predicted for accepted last bytes, oldest first.
    logic        expected_flags [$];
    // Bytes of the document being assembled by a test.
    logic [7:0]  doc_bytes [$];

    int unsigned error_count   = 0;
    int unsigned flags_checked = 0;
    int unsigned bytes_sent    = 0;
    int unsigned docs_sent     = 0;
    int unsigned cycle_count   = 0;

    // ------------------------------------------------------------------------
    // Clock, and the watchdog that ends a run which goes past the cycle limit.
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("Timeout after %0d cycles, %0d flags still expected",
                     cycle_count, expected_flags.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: ready changes on the falling edge. A hold request from a test
    // keeps ready low for that many cycles; otherwise it stalls at random.
    // ------------------------------------------------------------------------
    initial begin
        flag_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (flag_hold_cycles != 0) begin
                flag_bus.ready <= 1'b0;
                flag_hold_cycles--;
            end else begin
                flag_bus.ready <= ($urandom_range(99, 0) >= sink_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Decoder model.
    // ------------------------------------------------------------------------
    function automatic logic script_hit(input logic [20:0] cp);
        for (int k = 0; k < ScriptCount; k++) begin
            if (cp >= ScriptLo[k] && cp <= ScriptHi[k]) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic clear_document();
        doc_pos     = '0;
        cont_left   = '0;
        partial_cp  = '0;
        script_seen = 1'b0;
    endtask

    // Advances the model by one accepted byte. Only bytes inside the window
    // touch the decode state, but every byte moves the position on, which
    // stops at its all-ones value. A last byte queues the sticky flag and
    // starts a fresh document.
    task automatic scan_byte(input logic [7:0] value, input logic last);
        if (doc_pos < win_limit) begin
            if (cont_left != 0) begin
                // Continuation bytes are not checked: the low six bits are
                // shifted in whatever the top two bits are.
                partial_cp = {partial_cp[14:0], value[5:0]};
                cont_left--;
                if (cont_left == 0 && script_hit(partial_cp)) begin
                    script_seen = 1'b1;
                end
            end else if ((value & Lead2Mask) == Lead2Tag) begin
                partial_cp = {16'd0, value[4:0]};
                cont_left  = 2'd1;
            end else if ((value & Lead3Mask) == Lead3Tag) begin
                partial_cp = {17'd0, value[3:0]};
                cont_left  = 2'd2;
            end else if ((value & Lead4Mask) == Lead4Tag) begin
                partial_cp = {18'd0, value[2:0]};
                cont_left  = 2'd3;
            end
        end
        if (doc_pos != PosSat) begin
            doc_pos++;
        end
        if (last) begin
            expected_flags.push_back(script_seen);
            clear_document();
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Monitor on the rising edge. The result is checked before the byte of
    // the same edge is fed to the model, so a flag can never be matched
    // against an expectation that its own request created.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            clear_document();
            win_limit = LimitAtReset;
        end else begin
            if ($isunknown(flag_bus.valid)) begin
                report_mismatch("flag valid is unknown");
            end else if (flag_bus.valid && flag_bus.ready) begin
                if (expected_flags.size() == 0) begin
                    report_mismatch($sformatf("flag %b offered with none expected",
                                              flag_bus.non_english_found));
                end else begin
                    logic want;
                    want = expected_flags.pop_front();
                    flags_checked++;
                    if (flag_bus.non_english_found !== want) begin
                        report_mismatch($sformatf("flag %0d: got %b, expected %b",
                                                  flags_checked,
                                                  flag_bus.non_english_found, want));
                    end
                end
            end
            if (cfg_bus.valid && cfg_bus.ready) begin
                win_limit = cfg_bus.check_limit;
            end
            if (byte_bus.valid && byte_bus.ready) begin
                scan_byte(byte_bus.data_byte, byte_bus.end_of_doc);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. Every task below is entered and left on a falling
    // edge, so inputs never change on the rising edge that samples them.
    // ------------------------------------------------------------------------

    // Sends one byte request, after a random gap when the sender is paced.
    // On return valid is still high with the accepted byte: the caller either
    // sends again straight away or drops valid through wait_for_idle.
    task automatic send_byte(input logic [7:0] value, input logic last);
        int unsigned gap;
        gap = 0;
        while (gap < MaxGap && $urandom_range(99, 0) < src_idle_pct) begin
            gap++;
        end
        if (gap != 0) begin
            byte_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_bus.valid      <= 1'b1;
        byte_bus.data_byte  <= value;
        byte_bus.end_of_doc <= last;
        @(posedge clk);
        while (byte_bus.ready !== 1'b1) begin
            @(posedge clk);
        end
        @(negedge clk);
        bytes_sent++;
    endtask

    // Sends the assembled document with the last byte flagged.
    task automatic send_document();
        foreach (doc_bytes[i]) begin
            send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
        end
        docs_sent++;
    endtask

    // Stops sending and waits until every predicted flag has been taken,
    // then lets the pipeline settle.
    task automatic wait_for_idle();
        byte_bus.valid <= 1'b0;
        while (expected_flags.size() != 0) begin
            @(negedge clk);
        end
        repeat (DrainCycles) @(negedge clk);
    endtask

    // Writes the scan window; only called while the core is idle.
    task automatic write_limit(input logic [15:0] value);
        cfg_bus.valid       <= 1'b1;
        cfg_bus.check_limit <= value;
        @(posedge clk);
        while (cfg_bus.ready !== 1'b1) begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic set_pacing(input int unsigned src_pct, input int unsigned sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    // Top bits of a continuation byte: usually the proper tag, now and then
    // anything, since the core does not check them.
    function automatic logic [1:0] cont_top();
        if ($urandom_range(9, 0) == 0) begin
            return 2'($urandom_range(3, 0));
        end
        return ContTag;
    endfunction

    // Appends a code point encoded in len bytes (2 to 4); short code points
    // in a long form give overlong encodings, which the core accepts.
    task automatic push_code_point(input logic [20:0] cp, input int unsigned len);
        case (len)
            2: begin
                doc_bytes.push_back(Lead2Tag | {3'd0, cp[10:6]});
                doc_bytes.push_back({cont_top(), cp[5:0]});
            end
            3: begin
                doc_bytes.push_back(Lead3Tag | {4'd0, cp[15:12]});
                doc_bytes.push_back({cont_top(), cp[11:6]});
                doc_bytes.push_back({cont_top(), cp[5:0]});
            end
            default: begin
                doc_bytes.push_back(Lead4Tag | {5'd0, cp[20:18]});
                doc_bytes.push_back({cont_top(), cp[17:12]});
                doc_bytes.push_back({cont_top(), cp[11:6]});
                doc_bytes.push_back({cont_top(), cp[5:0]});
            end
        endcase
    endtask

    // Builds a random document: mostly whole code points near or inside the
    // script ranges, mixed with ASCII, raw noise bytes and sequences whose
    // tail is missing. The final cut can leave a sequence open at the end.
    task automatic build_random_document();
        int unsigned target;
        int unsigned kind;
        int unsigned k;
        int unsigned len;
        logic [20:0] cp;
        doc_bytes.delete();
        target = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        while (doc_bytes.size() < target) begin
            kind = $urandom_range(19, 0);
            k    = $urandom_range(ScriptCount - 1, 0);
            case ($urandom_range(5, 0))
                0:       cp = ScriptLo[k] - 21'd1;
                1:       cp = ScriptLo[k];
                2:       cp = ScriptHi[k];
                3:       cp = ScriptHi[k] + 21'd1;
                4:       cp = 21'($urandom_range(ScriptHi[k], ScriptLo[k]));
                default: cp = 21'($urandom_range(21'h1FFFFF, 0));
            endcase
            len = (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
            if (len < 4 && $urandom_range(5, 0) == 0) begin
                len++;
            end
            if (kind < 10) begin
                push_code_point(cp, len);
            end else if (kind < 15) begin
                doc_bytes.push_back(8'($urandom_range(127, 0)));
            end else if (kind < 18) begin
                doc_bytes.push_back(8'($urandom_range(255, 0)));
            end else begin
                // Broken sequence: the lead survives, part of the tail does
                // not, so following bytes are taken as its continuation.
                len = $urandom_range(4, 2);
                push_code_point(cp, len);
                repeat ($urandom_range(len - 1, 1)) void'(doc_bytes.pop_back());
            end
        end
        while (doc_bytes.size() > target) begin
            void'(doc_bytes.pop_back());
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Window left at its reset value: range edges, each lead length, an
    // overlong form, cut and invalid sequences, unchecked continuation bytes.
    task automatic test_default_window();
        set_pacing(0, 0);
        doc_bytes = '{8'h41};                      send_document(); // ASCII only
        doc_bytes = '{8'hD0, 8'h80};               send_document(); // U+0400, completed by the last byte
        doc_bytes = '{8'hE4, 8'hB8, 8'h80};        send_document(); // U+4E00, lowest CJK
        doc_bytes = '{8'hED, 8'h9E, 8'hA4};        send_document(); // U+D7A4, just past Hangul
        doc_bytes = '{8'hF0, 8'h80, 8'hB8, 8'h80}; send_document(); // overlong Thai U+0E00
        doc_bytes = '{8'hE4, 8'hB8};               send_document(); // cut by the end of the document
        doc_bytes = '{8'hFF, 8'hF8, 8'h80};        send_document(); // bytes that are not leads
        doc_bytes = '{8'hD0, 8'h41};               send_document(); // ASCII taken as continuation
        doc_bytes = '{8'hD0, 8'h80, 8'h41};        send_document(); // flag stays set
        wait_for_idle();
    endtask

    // Narrow windows, including a zero window and a sequence left pending
    // when the window closes.
    task automatic test_window_edges();
        write_limit(16'd0);
        doc_bytes = '{8'hD0, 8'h80};               send_document();
        wait_for_idle();
        write_limit(16'd1);
        doc_bytes = '{8'hD0, 8'h80};               send_document();
        wait_for_idle();
        write_limit(16'd2);
        doc_bytes = '{8'hD0, 8'h80};               send_document();
        doc_bytes = '{8'hD0, 8'h80};               send_document(); // position cleared between documents
        wait_for_idle();
        write_limit(16'd3);
        doc_bytes = '{8'h41, 8'hE4, 8'hB8, 8'h80}; send_document();
        wait_for_idle();
    endtask

    // Documents that fill or run past the window. In the first the sequence
    // completes on the last scanned position; in the second its lead sits
    // there, so it stays pending and nothing after it is scanned.
    task automatic test_long_document();
        set_pacing(0, 0);
        write_limit(16'd20);
        repeat (18) send_byte(8'h61, 1'b0);
        send_byte(8'hD0, 1'b0);
        send_byte(8'h90, 1'b1);
        docs_sent++;
        repeat (19) send_byte(8'h61, 1'b0);
        send_byte(8'hD0, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'hD0, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'hD0, 1'b0);
        send_byte(8'h90, 1'b1);
        docs_sent++;
        wait_for_idle();
    endtask

    // The receiver holds off for a long stretch while short documents keep
    // coming, so a pending flag stalls the next last byte. Afterwards the
    // sender waits for every flag before it sends once more.
    task automatic test_held_receiver();
        set_pacing(0, 0);
        write_limit(LimitAtReset);
        flag_hold_cycles = 120;
        repeat (8) begin
            doc_bytes = '{8'hD0, 8'h80};
            send_document();
        end
        wait_for_idle();
        doc_bytes = '{8'hE4, 8'hB8, 8'h80};
        send_document();
        wait_for_idle();
    endtask

    // Random documents under four pacing profiles, each with a small window
    // and then a wider one.
    task automatic test_random_traffic();
        int unsigned src_pcts [4];
        int unsigned sink_pcts [4];
        int unsigned phase_start;
        logic [15:0] limit;
        src_pcts  = '{0, 87, 0, 10};
        sink_pcts = '{0, 0, 87, 10};
        for (int p = 0; p < 4; p++) begin
            set_pacing(src_pcts[p], sink_pcts[p]);
            for (int half = 0; half < 2; half++) begin
                if (half == 0) begin
                    limit = 16'($urandom_range(24, 1));
                end else begin
                    case (p)
                        0:       limit = 16'hFFFF;
                        1:       limit = 16'($urandom_range(65535, 25));
                        2:       limit = LimitAtReset;
                        default: limit = 16'($urandom_range(200, 25));
                    endcase
                end
                wait_for_idle();
                write_limit(limit);
                phase_start = bytes_sent;
                while (bytes_sent - phase_start < 55) begin
                    build_random_document();
                    send_document();
                end
            end
        end
        wait_for_idle();
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------------
    initial begin
        rst_n               = 1'b0;
        byte_bus.valid      = 1'b0;
        byte_bus.data_byte  = 8'd0;
        byte_bus.end_of_doc = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.check_limit = 16'd0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_window();
        test_window_edges();
        test_long_document();
        test_held_receiver();
        test_random_traffic();

        $display("Checked %0d flags over %0d documents (%0d bytes), windows from 0 to 65535,",
                 flags_checked, docs_sent, bytes_sent);
        $display("with held and stalled results, sender gaps and documents past the window.");
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
